@@ rtl/b64enc_pkg.sv @@
package b64enc_pkg;

  localparam int unsigned JobqDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_e;

  // One accepted byte turns into up to four characters.
  typedef struct packed {
    logic [3:0][5:0] code;
    logic [3:0]      pad;
    logic [1:0]      last_idx;
    logic            eom;
  } job_t;

  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] c;
    begin
      c = {2'b00, v};
      if (v < 6'd26) begin
        c = 8'h41 + c;
      end else if (v < 6'd52) begin
        c = 8'h61 + c - 8'd26;
      end else if (v < 6'd62) begin
        c = 8'h30 + c - 8'd52;
      end else if (v == 6'd62) begin
        c = 8'h2B;
      end else begin
        c = 8'h2F;
      end
      return c;
    end
  endfunction

endpackage

@@ rtl/b64enc_front.sv @@
module b64enc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               is_last_i,
  output b64enc_pkg::job_t   job_o
);
  import b64enc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  job_t       job;

  always_comb begin
    job      = '0;
    phase_d  = phase_q;
    left_d   = left_q;
    job.eom  = is_last_i;
    unique case (phase_q)
      PH_1: begin
        job.code[0] = {left_q[1:0], data_byte_i[7:4]};
        if (is_last_i) begin
          job.code[1]  = {data_byte_i[3:0], 2'b00};
          job.pad[2]   = 1'b1;
          job.last_idx = 2'd2;
          phase_d      = PH_0;
          left_d       = '0;
        end else begin
          phase_d = PH_2;
          left_d  = data_byte_i[3:0];
        end
      end
      PH_2: begin
        job.code[0]  = {left_q, data_byte_i[7:6]};
        job.code[1]  = data_byte_i[5:0];
        job.last_idx = 2'd1;
        phase_d      = PH_0;
        left_d       = '0;
      end
      default: begin
        job.code[0] = data_byte_i[7:2];
        if (is_last_i) begin
          job.code[1]  = {data_byte_i[1:0], 4'b0000};
          job.pad[2]   = 1'b1;
          job.pad[3]   = 1'b1;
          job.last_idx = 2'd3;
          phase_d      = PH_0;
          left_d       = '0;
        end else begin
          phase_d = PH_1;
          left_d  = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ rtl/b64enc_jobq.sv @@
module b64enc_jobq #(
  parameter int unsigned Depth = b64enc_pkg::JobqDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  b64enc_pkg::job_t wr_job_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output b64enc_pkg::job_t rd_job_o
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign valid_o  = (cnt_q != '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !rd_i |-> !wr_i) else $error("jobq write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o) else $error("jobq read while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("jobq count out of range");

endmodule

@@ rtl/b64enc_back.sv @@
module b64enc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  b64enc_pkg::job_t job_i,
  output logic             job_done_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_char_o,
  output logic             end_of_message_o
);
  import b64enc_pkg::*;

  logic [1:0] idx_q;
  logic       ovalid_q;
  logic [7:0] char_q, char_d;
  logic       eom_q;
  logic       load;
  logic       at_end;

  assign load       = job_valid_i && (!ovalid_q || pop_i);
  assign at_end     = (idx_q == job_i.last_idx);
  assign job_done_o = load && at_end;
  assign char_d     = job_i.pad[idx_q] ? PadChar : enc6(job_i.code[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q    <= at_end ? 2'd0 : idx_q + 2'd1;
        ovalid_q <= 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      eom_q  <= job_i.eom && at_end;
    end
  end

  assign empty_o          = !ovalid_q;
  assign out_char_o       = char_q;
  assign end_of_message_o = eom_q;

  a_idx_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> job_valid_i) else $error("char index without a job");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q <= job_i.last_idx) else $error("char index past job end");
  a_eom_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !job_done_o |=> !eom_q) else $error("end mark before job end");

endmodule

@@ rtl/base64_stream_encoder_top.sv @@
// Streaming base64 encoder (standard alphabet, '=' padding). Each item is one
// message byte with a last-byte flag; results are ASCII characters, the final
// character of a message flagged by end_of_message_o. A byte yields one or two
// characters, or three or four on the last byte when the group is padded. The
// output side delivers one character per cycle while pop is held, which sets
// the sustained rate: about four characters per three bytes in steady state, plus
// the padding burst at message end. The front takes one byte per cycle while the
// job queue (JobqDepth entries) has room, so input and output stall independently.
module base64_stream_encoder_top #(
  parameter int unsigned JobqDepth = b64enc_pkg::JobqDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       end_of_message_o
);
  import b64enc_pkg::*;

  logic accept;
  job_t front_job, head_job;
  logic head_valid, job_done;

  assign accept = push && !full;

  b64enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .job_o       (front_job)
  );

  b64enc_jobq #(
    .Depth (JobqDepth)
  ) u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (front_job),
    .full_o   (full),
    .rd_i     (job_done),
    .valid_o  (head_valid),
    .rd_job_o (head_job)
  );

  b64enc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (head_valid),
    .job_i            (head_job),
    .job_done_o       (job_done),
    .pop_i            (pop),
    .empty_o          (empty),
    .out_char_o       (out_char_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule
